### src/olir_pkg.sv
// Shared types, codes and sizes for the ordered list insert/remove block.
package olir_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    // Width used for position and count compares; at least as wide as the position field.
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_ACCESS = 2'd2,
        ACT_SEARCH = 2'd3
    } olir_action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } olir_status_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic              ins_go;
        logic              rem_go;
        logic              cmp_go;
        logic [CMP_W-1:0]  pos;
        logic [CMP_W-1:0]  count;
        logic signed [7:0] value;
    } olir_cmd_t;

endpackage

### src/olir_cell.sv
// One list cell: holds one entry, shifts with its neighbors and compares against a key.
module olir_cell
    import olir_pkg::*;
(
    input  logic              clk,
    input  olir_cmd_t         cmd,
    input  logic [CMP_W-1:0]  index,
    input  logic signed [7:0] left_entry,
    input  logic signed [7:0] right_entry,
    output logic signed [7:0] entry,
    output logic              hit
);

    logic signed [7:0] entry_reg;
    logic signed [7:0] entry_next;
    logic              hit_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins_go)
        begin
            if (index == cmd.pos)
            begin
                entry_next = cmd.value;
            end
            else if (index > cmd.pos)
            begin
                entry_next = left_entry;
            end
        end
        else if (cmd.rem_go)
        begin
            if (index >= cmd.pos)
            begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (cmd.cmp_go)
        begin
            // Only cells below the count take part in a search.
            hit_reg <= (entry_reg == cmd.value) && (index < cmd.count);
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

### src/olir_first.sv
// Priority encoder that finds the lowest cell reporting a match.
module olir_first
    import olir_pkg::*;
(
    input  logic [DEPTH-1:0] hits,
    output logic             any_hit,
    output logic [CMP_W-1:0] first
);

    always_comb
    begin
        first = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                first = CMP_W'(i);
            end
        end
    end

    assign any_hit = |hits;

endmodule

### src/ordered_list_insert_remove.sv
// Top level of the ordered list block: control, cell chain and result register.
//
//  Channel   Direction  Word layout (low bit first)
//  s_axis    in         action[1:0] position[5:2] value[13:6], zero pad to 16 bits
//  m_axis    out        status[1:0] data[9:2] found_index[13:10] count[18:14]
//                       is_full[19] is_empty[20], zero pad to 24 bits
//
// Each action is taken in the idle state and then resolved. In the accept cycle every cell shifts for insert or
// remove, or compares its entry for a search, all in parallel; in the resolve cycle
// the priority encoder settles a search and the result word enters the output register.
// s_tready returns once the result word is loaded, so a new action waits until the last one has resolved.
// Only a result that finds the output register still occupied stalls the resolve cycle.
// Reset clears the count, control state and output valid; entries hold no reset value.
module ordered_list_insert_remove
    import olir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // action, position, value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status, data, found_index, count, is_full, is_empty
);

    typedef enum logic [1:0] {
        S_IDLE    = 2'b01,
        S_RESOLVE = 2'b10
    } olir_state_t;

    olir_state_t       state_reg;
    olir_state_t       state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    olir_status_t      status_reg;
    olir_status_t      status_next;
    logic              search_reg;
    logic signed [7:0] data_reg;
    logic signed [7:0] data_next;

    logic              m_tvalid_reg;
    logic [23:0]       m_tdata_reg;

    // Decoded input word.
    olir_action_t      action;
    logic [3:0]        position;
    logic signed [7:0] value;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  count_ext;
    logic              s_fire;
    logic              load_out;

    olir_cmd_t         cmd;
    logic signed [7:0] entry_w [DEPTH];
    logic [DEPTH-1:0]  hit_w;
    logic              any_hit;
    logic [CMP_W-1:0]  first_idx;
    logic signed [7:0] access_entry;

    olir_status_t      res_status;
    logic [3:0]        res_found;
    logic              res_full;
    logic              res_empty;

    assign action    = olir_action_t'(s_tdata[1:0]);
    assign position  = s_tdata[5:2];
    assign value     = s_tdata[13:6];
    assign pos_ext   = CMP_W'(position);
    assign count_ext = CMP_W'(count_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign load_out = (state_reg == S_RESOLVE) && (!m_tvalid_reg || m_tready);

    // Status, new count and read data decided in the accept cycle.
    always_comb
    begin
        status_next = ST_OK;
        count_next  = count_reg;
        data_next   = '0;
        cmd.ins_go  = 1'b0;
        cmd.rem_go  = 1'b0;
        cmd.cmp_go  = s_fire && (action == ACT_SEARCH);
        cmd.pos     = pos_ext;
        cmd.count   = count_ext;
        cmd.value   = value;
        case (action)
            ACT_INSERT:
            begin
                if (count_reg == CNT_W'(DEPTH))
                begin
                    status_next = ST_FULL;
                end
                else if (pos_ext > count_ext)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    cmd.ins_go = s_fire;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_REMOVE:
            begin
                if (pos_ext >= count_ext)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    cmd.rem_go = s_fire;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ACT_ACCESS:
            begin
                if (pos_ext >= count_ext)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    data_next = access_entry;
                end
            end
            default:
            begin
                // Search: the outcome is settled in the resolve cycle.
                status_next = ST_NOT_FOUND;
            end
        endcase
    end

    // Read port for access: select the cell whose index equals the position.
    always_comb
    begin
        access_entry = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (CMP_W'(i) == pos_ext)
            begin
                access_entry = entry_w[i];
            end
        end
    end

    // The cell chain. Cell zero has no left neighbor and the last cell no right one.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [7:0] left_w;
        logic signed [7:0] right_w;

        if (g == 0)
        begin : g_head
            assign left_w = value;
        end
        else
        begin : g_body
            assign left_w = entry_w[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign right_w = entry_w[g];
        end
        else
        begin : g_link
            assign right_w = entry_w[g+1];
        end

        olir_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .index       (CMP_W'(g)),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entry_w[g]),
            .hit         (hit_w[g])
        );
    end

    olir_first u_first (
        .hits    (hit_w),
        .any_hit (any_hit),
        .first   (first_idx)
    );

    // Result assembly in the resolve cycle.
    always_comb
    begin
        res_status = status_reg;
        res_found  = '0;
        if (search_reg && any_hit)
        begin
            res_status = ST_OK;
            res_found  = first_idx[3:0];
        end
        res_full  = (count_reg == CNT_W'(DEPTH));
        res_empty = (count_reg == '0);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (s_fire)
            begin
                count_reg <= count_next;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            status_reg <= status_next;
            search_reg <= (action == ACT_SEARCH);
            data_reg   <= data_next;
        end
        if (load_out)
        begin
            m_tdata_reg <= {3'b000, res_empty, res_full, 5'(count_reg), res_found,
                            data_reg, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // The entry count never passes the list capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds capacity");

    // The count changes only at an accepted word.
    a_count_still: assert property (@(posedge clk) disable iff (!rst_n)
        !s_fire |=> $stable(count_reg))
        else $error("count changed without an accepted word");

    // Every accepted word is followed by its resolve cycle.
    a_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> (state_reg == S_RESOLVE))
        else $error("accepted word not resolved");

    // A result is never full and empty at once.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[19] && m_tdata[20]))
        else $error("full and empty flags both set");
`endif

endmodule

### sim/olir_checker.sv
// Checker for the ordered list block: predicts every result word and compares it field by field.
module olir_checker
    import olir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // action, position, value
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // status, data, found_index, count, is_full, is_empty
    output int          mismatches,
    output int          outstanding
);

    // Same bit order as the result word, lowest field last in the declaration.
    typedef struct packed {
        logic              is_empty;
        logic              is_full;
        logic [4:0]        count;
        logic [3:0]        found_index;
        logic signed [7:0] data;
        olir_status_t      status;
    } list_result_t;

    logic signed [7:0] list_mem [DEPTH];
    int                list_len;
    list_result_t      predicted_results [$];
    int                fail_total;

    // Applies one action to the shadow list and returns the result it should give.
    function automatic list_result_t apply_action(olir_action_t act, logic [3:0] pos,
                                                  logic signed [7:0] val);
        list_result_t r;
        int           i;
        r = '0;
        r.status = ST_OK;
        case (act)
            ACT_INSERT:
            begin
                if (list_len >= DEPTH)
                    r.status = ST_FULL;
                else if (pos > list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = list_len; i > pos; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[pos] = val;
                    list_len++;
                end
            end
            ACT_REMOVE:
            begin
                if (pos >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = pos; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
            ACT_ACCESS:
            begin
                if (pos >= list_len)
                    r.status = ST_RANGE;
                else
                    r.data = list_mem[pos];
            end
            default:
            begin
                r.status = ST_NOT_FOUND;
                for (i = 0; i < list_len; i++)
                begin
                    if (r.status == ST_NOT_FOUND && list_mem[i] == val)
                    begin
                        r.status = ST_OK;
                        r.found_index = i[3:0];
                    end
                end
            end
        endcase
        r.count    = list_len[4:0];
        r.is_full  = (list_len == DEPTH);
        r.is_empty = (list_len == 0);
        return r;
    endfunction

    task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        list_result_t want;
        if (!rst_n)
        begin
            list_len = 0;
            fail_total = 0;
            predicted_results.delete();
        end
        else
        begin
            // The prediction is queued first so that a result taken at the same edge as its word would still match.
            if (s_tvalid && s_tready)
                predicted_results.push_back(apply_action(olir_action_t'(s_tdata[1:0]),
                                                         s_tdata[5:2], $signed(s_tdata[13:6])));
            if (m_tvalid && m_tready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, m_tdata);
                    fail_total++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("status", want.status, m_tdata[1:0]);
                    check_field("data", want.data, $signed(m_tdata[9:2]));
                    check_field("found_index", want.found_index, m_tdata[13:10]);
                    check_field("count", want.count, m_tdata[18:14]);
                    check_field("is_full", want.is_full, m_tdata[19]);
                    check_field("is_empty", want.is_empty, m_tdata[20]);
                    check_field("padding", 0, m_tdata[23:21]);
                end
            end
        end
        mismatches  <= fail_total;
        outstanding <= predicted_results.size();
    end

endmodule

### sim/testbench.sv
// Top of the ordered list testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench
    import olir_pkg::*;
();

    // A hold-off of the receiver long enough to fill the output register and the
    // resolve stage, so the block has to drop s_tready while the sender keeps offering.
    localparam int HOLD_CYCLES      = 60;
    // Cycles without any accepted word before the run is declared hung.
    localparam int WATCHDOG_LIMIT   = 2000;
    // Margin after the final drain that covers the resolve state and the output register.
    localparam int TAIL_CYCLES      = 10;
    localparam int RANDOM_PER_PHASE = 545;

    // Stimulus modes: growing runs fill the list, shrinking runs empty it.
    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIXED  = 2;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int   mismatches;
    int   outstanding;

    // Percent chance of an idle cycle on each side; changed between phases.
    int   send_pct  = 0;
    int   recv_pct  = 0;
    // The stimulus toggles hold_req to ask the receiver for one long hold-off;
    // only the receiver process writes hold_ack and hold_left.
    logic hold_req  = 1'b0;
    logic hold_ack  = 1'b0;
    int   hold_left = 0;

    ordered_list_insert_remove uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    olir_checker list_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Receiver: random stalls at recv_pct, or a solid hold-off when one is requested.
    initial
    begin : receiver
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_ack)
            begin
                hold_ack = hold_req;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_pct);
        end
    end

    // Watchdog: any accepted word on either side restarts the count.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Offers one action word and returns at the edge where it is accepted. Idle
    // cycles come before the word, so s_tvalid is only lowered when a gap follows
    // and is never lowered and raised again in the same step.
    task automatic put_action(olir_action_t act, logic [3:0] pos, logic signed [7:0] val);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {2'b00, val, pos, act};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stops offering and waits until every predicted result has been taken. The
    // first edge is always waited out, since the checker's count is registered.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Half the values come from a small pool so that searches hit, often on
    // duplicates; the other half sweep every bit pattern.
    function automatic logic signed [7:0] pick_value();
        logic signed [7:0] pool [8];
        pool = '{-8'sd128, -8'sd1, 8'sd0, 8'sd1, 8'sd127, 8'sd5, -8'sd7, 8'sd64};
        if ($urandom_range(0, 1))
            return pool[$urandom_range(0, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_item(int mode);
        int           roll;
        olir_action_t act;
        logic [3:0]   pos;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_GROW:
                act = (roll < 70) ? ACT_INSERT : (roll < 80) ? ACT_REMOVE :
                      (roll < 90) ? ACT_ACCESS : ACT_SEARCH;
            MODE_SHRINK:
                act = (roll < 10) ? ACT_INSERT : (roll < 70) ? ACT_REMOVE :
                      (roll < 85) ? ACT_ACCESS : ACT_SEARCH;
            default:
                act = olir_action_t'($urandom_range(0, 3));
        endcase
        // Low positions are valid on a short list and hit the append point often;
        // the full range reaches the top entries of a full list and the range errors.
        if ($urandom_range(0, 1))
            pos = 4'($urandom_range(0, 3));
        else
            pos = 4'($urandom_range(0, 15));
        put_action(act, pos, pick_value());
    endtask

    // Random actions in segments of one mode each, so the list swings between
    // empty and full. One phase also gets the long receiver hold-off.
    task automatic random_phase(int n_items, bit with_hold);
        int mode;
        int seg_left;
        seg_left = 0;
        mode = MODE_MIXED;
        for (int k = 0; k < n_items; k++)
        begin
            if (seg_left == 0)
            begin
                mode = $urandom_range(MODE_GROW, MODE_MIXED);
                seg_left = $urandom_range(8, 40);
            end
            seg_left--;
            if (k == n_items / 4)
                wait_results_drained();
            if (with_hold && k == n_items / 2)
                hold_req <= ~hold_req;
            random_item(mode);
        end
    endtask

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting from an empty list.
        put_action(ACT_SEARCH, 4'd0, 8'sd0);      // search on an empty list
        put_action(ACT_REMOVE, 4'd0, 8'sd0);      // remove on an empty list
        put_action(ACT_ACCESS, 4'd0, 8'sd0);      // access on an empty list
        put_action(ACT_INSERT, 4'd1, 8'sd9);      // insert past the end
        put_action(ACT_INSERT, 4'd0, -8'sd128);
        put_action(ACT_INSERT, 4'd1, 8'sd127);    // append at position equal to count
        put_action(ACT_INSERT, 4'd0, 8'sd0);      // insert at the front
        put_action(ACT_INSERT, 4'd2, -8'sd1);     // insert in the middle
        put_action(ACT_INSERT, 4'd5, 8'sd3);      // past the end of a longer list
        for (int p = 0; p < 4; p++)
            put_action(ACT_ACCESS, 4'(p), 8'sd0);
        put_action(ACT_ACCESS, 4'd4, 8'sd0);      // position equal to count
        put_action(ACT_ACCESS, 4'd15, -8'sd1);    // highest position
        put_action(ACT_SEARCH, 4'd0, 8'sd127);    // match in the last entry
        put_action(ACT_SEARCH, 4'd15, -8'sd128);
        put_action(ACT_SEARCH, 4'd0, 8'sd55);     // no match
        put_action(ACT_INSERT, 4'd4, -8'sd1);     // duplicate value
        put_action(ACT_SEARCH, 4'd0, -8'sd1);     // first of two matches
        put_action(ACT_REMOVE, 4'd5, 8'sd0);      // remove past the end
        put_action(ACT_REMOVE, 4'd4, 8'sd0);      // remove the last entry
        put_action(ACT_REMOVE, 4'd0, 8'sd0);      // remove the first entry
        put_action(ACT_REMOVE, 4'd15, 8'sd0);
        wait_results_drained();

        // Sender idles more rarely than the receiver; the hold-off lands here.
        send_pct <= 29;
        recv_pct <= 47;
        random_phase(RANDOM_PER_PHASE, 1'b1);
        wait_results_drained();

        send_pct <= 47;
        recv_pct <= 29;
        random_phase(RANDOM_PER_PHASE, 1'b0);
        wait_results_drained();

        // Full rate on both sides.
        send_pct <= 0;
        recv_pct <= 0;
        random_phase(RANDOM_PER_PHASE, 1'b0);
        wait_results_drained();

        // Any stray result after the last one would show up in these cycles.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
